### sv/eipl4_pkg.sv
package eipl4_pkg;

   localparam int LEN_W   = 16;
   localparam int HDR_CAP = 34;
   localparam int HDR_AW  = $clog2(HDR_CAP);
   localparam int L4_CAP  = 16;
   localparam int L4_AW   = $clog2(L4_CAP);
   localparam int Q_DEPTH = 2;
   localparam int VAL_W   = 48;

   localparam logic [LEN_W-1:0] ETH_LEN = LEN_W'(14);
   localparam logic [LEN_W-1:0] IP_END  = LEN_W'(34);
   localparam logic [6:0]       TCP_MIN = 7'd20;
   localparam logic [6:0]       UDP_LEN = 7'd8;
   localparam logic [15:0]      ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]       PROTO_TCP  = 8'd6;
   localparam logic [7:0]       PROTO_UDP  = 8'd17;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_SHORT_ETH = 3'd1,
      STAT_SHORT_IP  = 3'd2,
      STAT_SHORT_TCP = 3'd3,
      STAT_SHORT_UDP = 3'd4,
      STAT_OVERSIZE  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      KIND_STATUS,
      KIND_ETH,
      KIND_IP,
      KIND_TCP,
      KIND_UDP
   } kind_type;

   typedef enum logic [4:0] {
      FLD_STATUS    = 5'd0,
      FLD_DMAC      = 5'd1,
      FLD_SMAC      = 5'd2,
      FLD_ETHERTYPE = 5'd3,
      FLD_IPVER     = 5'd4,
      FLD_IPHLEN    = 5'd5,
      FLD_PROTO     = 5'd6,
      FLD_SIP       = 5'd7,
      FLD_DIP       = 5'd8,
      FLD_SPORT     = 5'd9,
      FLD_DPORT     = 5'd10,
      FLD_SEQ       = 5'd11,
      FLD_ACK       = 5'd12,
      FLD_TCPOFF    = 5'd13,
      FLD_FLAGS     = 5'd14,
      FLD_WINDOW    = 5'd15,
      FLD_UDPLEN    = 5'd16,
      FLD_UDPSUM    = 5'd17,
      FLD_PAYOFF    = 5'd18,
      FLD_PAYLEN    = 5'd19
   } field_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [47:0]       dmac;
      logic [47:0]       smac;
      logic [15:0]       ethertype;
      logic [7:0]        ver_ihl;
      logic [7:0]        proto;
      logic [31:0]       sip;
      logic [31:0]       dip;
      logic [127:0]      l4;
      logic [7:0]        payoff;
      logic [LEN_W-1:0]  paylen;
   } desc_type;

endpackage

### sv/eipl4_front.sv
module eipl4_front import eipl4_pkg::*; #(
   parameter int MAX_PKT_LEN = 65535
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       q_full,
   output logic       q_push,
   output desc_type   q_desc
);

   logic [LEN_W-1:0] count_ff, count_in;
   logic             ov_ff, ov_in;
   logic             fin_ff, fin_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [6:0]       toff_ff, toff_in;
   logic [7:0]       hdr_ff [HDR_CAP];
   logic [7:0]       l4_ff [L4_CAP];

   logic             take;
   logic             sat;
   logic [6:0]       toff_now;
   logic [LEN_W-1:0] rel;

   logic [15:0]      etype;
   logic [7:0]       proto;
   logic [3:0]       doff;
   logic [16:0]      len_x;
   logic [16:0]      tcp_end;
   logic [16:0]      udp_end;
   logic [7:0]       payoff;

   assign in_ready = !fin_ff || !q_full;
   assign take     = in_valid && in_ready;
   assign q_push   = fin_ff && !q_full;
   assign sat      = count_ff >= LEN_W'(MAX_PKT_LEN);
   assign toff_now = (count_ff == ETH_LEN) ? (7'd14 + {1'b0, in_byte[3:0], 2'b00}) : toff_ff;
   assign rel      = count_ff - LEN_W'(toff_now);

   always_comb begin
      count_in = count_ff;
      ov_in    = ov_ff;
      fin_in   = q_push ? 1'b0 : fin_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      toff_in  = toff_ff;
      if (take) begin
         if (count_ff == ETH_LEN) begin
            toff_in = toff_now;
         end
         if (in_last) begin
            count_in = '0;
            ov_in    = 1'b0;
            fin_in   = 1'b1;
            len_in   = sat ? count_ff : count_ff + 1'b1;
            ovf_in   = ov_ff | sat;
         end else if (sat) begin
            ov_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ov_ff    <= 1'b0;
         fin_ff   <= 1'b0;
         toff_ff  <= 7'd14;
      end else begin
         count_ff <= count_in;
         ov_ff    <= ov_in;
         fin_ff   <= fin_in;
         toff_ff  <= toff_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      ovf_ff <= ovf_in;
      if (take && count_ff < LEN_W'(HDR_CAP)) begin
         hdr_ff[count_ff[HDR_AW-1:0]] <= in_byte;
      end
      if (take && count_ff >= LEN_W'(toff_now) && rel < LEN_W'(L4_CAP)) begin
         l4_ff[rel[L4_AW-1:0]] <= in_byte;
      end
   end

   // classify the finished packet while its bytes are still held
   always_comb begin
      etype   = {hdr_ff[12], hdr_ff[13]};
      proto   = hdr_ff[23];
      doff    = l4_ff[12][7:4];
      len_x   = {1'b0, len_ff};
      tcp_end = 17'(toff_ff) + 17'(TCP_MIN);
      udp_end = 17'(toff_ff) + 17'(UDP_LEN);
      payoff  = 8'd14;

      q_desc.kind      = KIND_STATUS;
      q_desc.status    = STAT_OK;
      q_desc.ethertype = etype;
      q_desc.ver_ihl   = hdr_ff[14];
      q_desc.proto     = proto;
      for (int i = 0; i < 6; i++) begin
         q_desc.dmac[(5-i)*8 +: 8] = hdr_ff[i];
         q_desc.smac[(5-i)*8 +: 8] = hdr_ff[6+i];
      end
      for (int i = 0; i < 4; i++) begin
         q_desc.sip[(3-i)*8 +: 8] = hdr_ff[26+i];
         q_desc.dip[(3-i)*8 +: 8] = hdr_ff[30+i];
      end
      for (int i = 0; i < L4_CAP; i++) begin
         q_desc.l4[(L4_CAP-1-i)*8 +: 8] = l4_ff[i];
      end

      if (ovf_ff) begin
         q_desc.status = STAT_OVERSIZE;
      end else if (len_ff < ETH_LEN) begin
         q_desc.status = STAT_SHORT_ETH;
      end else if (etype != ETYPE_IPV4) begin
         q_desc.kind = KIND_ETH;
      end else if (len_ff < IP_END) begin
         q_desc.status = STAT_SHORT_IP;
      end else if (proto == PROTO_TCP) begin
         if (len_x < tcp_end) begin
            q_desc.status = STAT_SHORT_TCP;
         end else begin
            q_desc.kind = KIND_TCP;
            payoff      = {1'b0, toff_ff} + {2'b00, doff, 2'b00};
         end
      end else if (proto == PROTO_UDP) begin
         if (len_x < udp_end) begin
            q_desc.status = STAT_SHORT_UDP;
         end else begin
            q_desc.kind = KIND_UDP;
            payoff      = {1'b0, toff_ff} + {1'b0, UDP_LEN};
         end
      end else begin
         q_desc.kind = KIND_IP;
         payoff      = {1'b0, toff_ff};
      end

      q_desc.payoff = payoff;
      q_desc.paylen = (LEN_W'(payoff) < len_ff) ? (len_ff - LEN_W'(payoff)) : '0;
   end

endmodule

### sv/eipl4_queue.sv
module eipl4_queue import eipl4_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type din,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output desc_type dout
);

   localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   desc_type        mem_ff [Q_DEPTH];
   logic [AW-1:0]   wp_ff, wp_in;
   logic [AW-1:0]   rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full  = cnt_ff == CW'(Q_DEPTH);
   assign valid = cnt_ff != '0;
   assign dout  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(Q_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(Q_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= din;
      end
   end

endmodule

### sv/eipl4_back.sv
module eipl4_back import eipl4_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  desc_type         q_desc,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [4:0]       out_code,
   output logic [VAL_W-1:0] out_value,
   output logic             out_last
);

   logic             act_ff, act_in;
   field_type        code_ff, code_in;
   desc_type         cur_ff;
   logic             vld_ff, vld_in;
   field_type        ocode_ff;
   logic [VAL_W-1:0] oval_ff;
   logic             olast_ff;

   logic             emit;
   logic             last;
   logic             load;
   field_type        nxt;
   logic [VAL_W-1:0] value;

   assign emit  = act_ff && (!vld_ff || out_ready);
   assign last  = (code_ff == FLD_PAYLEN) || (cur_ff.kind == KIND_STATUS);
   assign load  = q_valid && (!act_ff || (emit && last));
   assign q_pop = load;

   always_comb begin
      case (code_ff)
         FLD_STATUS:    value = VAL_W'(cur_ff.status);
         FLD_DMAC:      value = cur_ff.dmac;
         FLD_SMAC:      value = cur_ff.smac;
         FLD_ETHERTYPE: value = VAL_W'(cur_ff.ethertype);
         FLD_IPVER:     value = VAL_W'(cur_ff.ver_ihl[7:4]);
         FLD_IPHLEN:    value = VAL_W'({cur_ff.ver_ihl[3:0], 2'b00});
         FLD_PROTO:     value = VAL_W'(cur_ff.proto);
         FLD_SIP:       value = VAL_W'(cur_ff.sip);
         FLD_DIP:       value = VAL_W'(cur_ff.dip);
         FLD_SPORT:     value = VAL_W'(cur_ff.l4[127:112]);
         FLD_DPORT:     value = VAL_W'(cur_ff.l4[111:96]);
         FLD_SEQ:       value = VAL_W'(cur_ff.l4[95:64]);
         FLD_ACK:       value = VAL_W'(cur_ff.l4[63:32]);
         FLD_TCPOFF:    value = VAL_W'(cur_ff.l4[31:28]);
         FLD_FLAGS:     value = VAL_W'(cur_ff.l4[23:16]);
         FLD_WINDOW:    value = VAL_W'(cur_ff.l4[15:0]);
         FLD_UDPLEN:    value = VAL_W'(cur_ff.l4[95:80]);
         FLD_UDPSUM:    value = VAL_W'(cur_ff.l4[79:64]);
         FLD_PAYOFF:    value = VAL_W'(cur_ff.payoff);
         FLD_PAYLEN:    value = VAL_W'(cur_ff.paylen);
         default:       value = '0;
      endcase
   end

   always_comb begin
      case (code_ff)
         FLD_STATUS:    nxt = FLD_DMAC;
         FLD_ETHERTYPE: nxt = (cur_ff.kind == KIND_ETH) ? FLD_PAYOFF : FLD_IPVER;
         FLD_DIP:       nxt = (cur_ff.kind == KIND_IP) ? FLD_PAYOFF : FLD_SPORT;
         FLD_DPORT:     nxt = (cur_ff.kind == KIND_UDP) ? FLD_UDPLEN : FLD_SEQ;
         FLD_WINDOW:    nxt = FLD_PAYOFF;
         FLD_UDPSUM:    nxt = FLD_PAYOFF;
         default:       nxt = field_type'(code_ff + 5'd1);
      endcase
   end

   always_comb begin
      act_in  = act_ff;
      code_in = code_ff;
      vld_in  = vld_ff;
      if (emit) begin
         vld_in  = 1'b1;
         code_in = nxt;
         if (last) begin
            act_in = 1'b0;
         end
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
      if (load) begin
         act_in  = 1'b1;
         code_in = FLD_STATUS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         code_ff <= FLD_STATUS;
         vld_ff  <= 1'b0;
      end else begin
         act_ff  <= act_in;
         code_ff <= code_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_desc;
      end
      if (emit) begin
         ocode_ff <= code_ff;
         oval_ff  <= value;
         olast_ff <= last;
      end
   end

   assign out_valid = vld_ff;
   assign out_code  = ocode_ff;
   assign out_value = oval_ff;
   assign out_last  = olast_ff;

endmodule

### sv/eth_ipv4_l4_header_parser_top.sv
// Ethernet / IPv4 / TCP-UDP header parser. Packet bytes enter one per cycle on req_ with
// req_tlast on the final byte; headers are captured on the fly, so only the first 90 bytes
// matter and nothing needs clearing after reset. Once a packet's last byte is registered,
// its fields are checked and handed to a two-entry queue when it has room; the back end
// then sends the packet's run of records (one status record alone for a short or oversize
// packet, otherwise 6 to 18 records ending with payload offset and length) one record per
// cycle through an output register while rsp_tready allows, with rsp_tlast on the final
// record of the run. Input is held off only while a finished packet waits and the queue is
// full, which happens when runs are longer than the packets that follow them.
module eth_ipv4_l4_header_parser_top import eipl4_pkg::*; #(
   parameter int MAX_PKT_LEN = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [47:0] field_value
   output logic [4:0]  rsp_tuser,   // [4:0] field_code
   output logic        rsp_tlast
);

   logic     q_full;
   logic     q_push;
   desc_type push_desc;
   logic     q_valid;
   logic     q_pop;
   desc_type pop_desc;

   eipl4_front #(
      .MAX_PKT_LEN(MAX_PKT_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_desc   (push_desc)
   );

   eipl4_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (push_desc),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .dout  (pop_desc)
   );

   eipl4_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_desc    (pop_desc),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_code  (rsp_tuser),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

### tb/sv/tb_eth_ipv4_l4_header_parser_top.sv
`timescale 1ns / 1ps

module tb_eth_ipv4_l4_header_parser_top;
   import eipl4_pkg::*;

   localparam int HDR_DEPTH      = 128;
   localparam int LEN_LIMIT      = 65535;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 20;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_NOISE
   } fill_type;

   typedef struct packed {
      field_type   code;
      logic [47:0] value;
      logic        last;
   } field_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;

   // parser copy of the header bytes and length tracking
   logic [7:0]  hdr_copy [HDR_DEPTH];
   int          seen_len = 0;
   bit          len_overflow = 1'b0;

   field_rec_type pending_fields [$];
   logic [7:0]  frame_q [$];

   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;
   int          holds_asked = 0;
   int          holds_granted = 0;
   int          hold_left = 0;
   int          idle_cycles = 0;

   int          failures = 0;
   int          frames_done = 0;
   int          bytes_sent = 0;
   int          records_checked = 0;
   int          error_runs = 0;

   eth_ipv4_l4_header_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [47:0] hdr_field(input int pos, input int n);
      logic [47:0] v;
      v = '0;
      for (int i = 0; i < n; i++) begin
         v = {v[39:0], (pos + i < HDR_DEPTH) ? hdr_copy[pos + i] : 8'h00};
      end
      return v;
   endfunction

   function automatic void add_field(input field_type code, input logic [47:0] v,
                                     input logic last);
      field_rec_type r;
      r.code  = code;
      r.value = v;
      r.last  = last;
      pending_fields.push_back(r);
   endfunction

   function automatic void add_status_only(input status_type st);
      add_field(FLD_STATUS, 48'(st), 1'b1);
      error_runs++;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input bit l);
      int         len;
      int         off;
      int         hlen;
      int         doff;
      logic [7:0] proto;
      bit         too_long;
      if (seen_len < HDR_DEPTH) begin
         hdr_copy[seen_len] = b;
      end
      if (seen_len < LEN_LIMIT) begin
         seen_len++;
      end else begin
         len_overflow = 1'b1;
      end
      if (!l) begin
         return;
      end
      len          = seen_len;
      too_long     = len_overflow;
      seen_len     = 0;
      len_overflow = 1'b0;
      frames_done++;
      if (too_long) begin
         add_status_only(STAT_OVERSIZE);
         return;
      end
      if (len < 14) begin
         add_status_only(STAT_SHORT_ETH);
         return;
      end
      off = 14;
      if (hdr_field(12, 2) == 48'(ETYPE_IPV4)) begin
         if (len - off < 20) begin
            add_status_only(STAT_SHORT_IP);
            return;
         end
         hlen  = 4 * hdr_copy[14][3:0];
         proto = hdr_copy[23];
         off   = off + hlen;
         if (proto == PROTO_TCP && (off > len || len - off < 20)) begin
            add_status_only(STAT_SHORT_TCP);
            return;
         end
         if (proto == PROTO_UDP && (off > len || len - off < 8)) begin
            add_status_only(STAT_SHORT_UDP);
            return;
         end
         add_field(FLD_STATUS, 48'(STAT_OK), 1'b0);
         add_field(FLD_DMAC, hdr_field(0, 6), 1'b0);
         add_field(FLD_SMAC, hdr_field(6, 6), 1'b0);
         add_field(FLD_ETHERTYPE, 48'(ETYPE_IPV4), 1'b0);
         add_field(FLD_IPVER, 48'(hdr_copy[14][7:4]), 1'b0);
         add_field(FLD_IPHLEN, 48'(hlen), 1'b0);
         add_field(FLD_PROTO, 48'(proto), 1'b0);
         add_field(FLD_SIP, hdr_field(26, 4), 1'b0);
         add_field(FLD_DIP, hdr_field(30, 4), 1'b0);
         if (proto == PROTO_TCP) begin
            doff = int'(hdr_field(off + 12, 1) >> 4) & 15;
            add_field(FLD_SPORT, hdr_field(off, 2), 1'b0);
            add_field(FLD_DPORT, hdr_field(off + 2, 2), 1'b0);
            add_field(FLD_SEQ, hdr_field(off + 4, 4), 1'b0);
            add_field(FLD_ACK, hdr_field(off + 8, 4), 1'b0);
            add_field(FLD_TCPOFF, 48'(doff), 1'b0);
            add_field(FLD_FLAGS, hdr_field(off + 13, 1), 1'b0);
            add_field(FLD_WINDOW, hdr_field(off + 14, 2), 1'b0);
            off = off + 4 * doff;
         end else if (proto == PROTO_UDP) begin
            add_field(FLD_SPORT, hdr_field(off, 2), 1'b0);
            add_field(FLD_DPORT, hdr_field(off + 2, 2), 1'b0);
            add_field(FLD_UDPLEN, hdr_field(off + 4, 2), 1'b0);
            add_field(FLD_UDPSUM, hdr_field(off + 6, 2), 1'b0);
            off = off + 8;
         end
      end else begin
         add_field(FLD_STATUS, 48'(STAT_OK), 1'b0);
         add_field(FLD_DMAC, hdr_field(0, 6), 1'b0);
         add_field(FLD_SMAC, hdr_field(6, 6), 1'b0);
         add_field(FLD_ETHERTYPE, hdr_field(12, 2), 1'b0);
      end
      add_field(FLD_PAYOFF, 48'(off), 1'b0);
      add_field(FLD_PAYLEN, (off < len) ? 48'(len - off) : 48'd0, 1'b1);
   endfunction

   // receiver: random stalls, steady mode, and long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         holds_granted <= holds_granted + 1;
         hold_left     <= HOLD_CYCLES;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= rx_steady || ($urandom_range(0, 99) >= 25);
      end
   end

   always @(posedge clock) begin
      field_rec_type exp_rec;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fields.size() == 0) begin
            $display("%0t: unexpected record: expected none, actual code %0d value %h last %0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            exp_rec = pending_fields.pop_front();
            records_checked++;
            if (rsp_tuser !== exp_rec.code) begin
               $display("%0t: field_code expected %0d actual %0d",
                        $time, exp_rec.code, rsp_tuser);
               failures++;
            end
            if (rsp_tdata !== exp_rec.value) begin
               $display("%0t: field_value (code %0d) expected %h actual %h",
                        $time, exp_rec.code, exp_rec.value, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== exp_rec.last) begin
               $display("%0t: last_record (code %0d) expected %0b actual %0b",
                        $time, exp_rec.code, exp_rec.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d records outstanding",
                     $time, idle_cycles, pending_fields.size());
            $display("eth_ipv4_l4_header_parser_top regression: fail");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit l);
      while (!tx_steady && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      bytes_sent++;
      decode_byte(b, l);
   endtask

   task automatic send_frame(input fill_type fill, input logic [15:0] etype,
                             input logic [7:0] ver_ihl, input logic [7:0] proto,
                             input logic [3:0] doff, input int len);
      int         doff_pos;
      logic [7:0] b;
      frame_q.delete();
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: frame_q.push_back(8'h00);
            FILL_ONES: frame_q.push_back(8'hFF);
            default:   frame_q.push_back(8'($urandom));
         endcase
      end
      if (fill != FILL_NOISE) begin
         doff_pos = 26 + 4 * ver_ihl[3:0];
         if (len > 12) frame_q[12] = etype[15:8];
         if (len > 13) frame_q[13] = etype[7:0];
         if (len > 14) frame_q[14] = ver_ihl;
         if (len > 23) frame_q[23] = proto;
         if (proto == PROTO_TCP && len > doff_pos) begin
            b = frame_q[doff_pos];
            frame_q[doff_pos] = {doff, b[3:0]};
         end
      end
      for (int i = 0; i < len; i++) begin
         send_byte(frame_q[i], i == len - 1);
      end
   endtask

   task automatic drain_records();
      req_tvalid <= 1'b0;
      while (pending_fields.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_short_frames();
      send_frame(FILL_ZERO, 16'h0000, 8'h00, 8'h00, 4'h0, 1);
      send_frame(FILL_ONES, 16'hFFFF, 8'hFF, 8'hFF, 4'hF, 13);
      send_frame(FILL_ZERO, 16'h0000, 8'h00, 8'h00, 4'h0, 14);
   endtask

   task automatic test_ipv4_boundaries();
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h45, 8'd1, 4'h5, 33);
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h45, 8'd1, 4'h5, 34);
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h45, PROTO_TCP, 4'h5, 53);
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h45, PROTO_TCP, 4'h5, 54);
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h45, PROTO_UDP, 4'h5, 41);
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h45, PROTO_UDP, 4'h5, 42);
   endtask

   task automatic test_header_lengths();
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h40, PROTO_TCP, 4'h0, 34);
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h4F, PROTO_UDP, 4'h5, 40);
   endtask

   task automatic test_steady_stream();
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      send_frame(FILL_RANDOM, ETYPE_IPV4, 8'h45, PROTO_TCP, 4'hF, 54);
      send_frame(FILL_NOISE, 16'h0000, 8'h00, 8'h00, 4'h0, 20);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // output held off while input runs flat out, so the block backs up
   task automatic test_back_pressure();
      drain_records();
      tx_steady = 1'b1;
      holds_asked++;
      for (int n = 0; n < 7; n++) begin
         send_frame(FILL_RANDOM, 16'h0000, 8'h00, 8'h00, 4'h0, 4);
      end
      tx_steady = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_copy[i] = 8'h00;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_short_frames();
      test_ipv4_boundaries();
      test_header_lengths();
      test_steady_stream();
      test_back_pressure();
      drain_records();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d frames (%0d bytes), %0d records checked, %0d single-status runs",
               frames_done, bytes_sent, records_checked, error_runs);
      $display("short, truncated, odd header length, steady and stalled-output frames seen");
      if (failures == 0) begin
         $display("eth_ipv4_l4_header_parser_top regression: pass");
      end else begin
         $display("eth_ipv4_l4_header_parser_top regression: fail");
      end
      $finish;
   end

endmodule

### eth_ipv4_l4_header_parser_top.f
sv/eipl4_pkg.sv
sv/eipl4_front.sv
sv/eipl4_queue.sv
sv/eipl4_back.sv
sv/eth_ipv4_l4_header_parser_top.sv
tb/sv/tb_eth_ipv4_l4_header_parser_top.sv
